FILE: design/ssfb_pkg.sv
// shared types, constants and the segment table for the seven-segment frame builder
package ssfb_pkg;

  localparam int FRAME_LEN = 14;
  localparam int NUM_DIGITS = 4;
  localparam logic [7:0] DOT_BIT = 8'h80;
  localparam logic [7:0] COLON_BYTE = 8'h01;
  localparam logic [7:0] ZERO_BYTE = 8'h00;
  localparam int CFG_AW = 4;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_DISPLAY_MODE    = 2'd0,
    REG_DATA_COMMAND    = 2'd1,
    REG_START_ADDRESS   = 2'd2,
    REG_DISPLAY_CONTROL = 2'd3
  } reg_idx_t;

  localparam logic [7:0] RST_DISPLAY_MODE    = 8'h01;
  localparam logic [7:0] RST_DATA_COMMAND    = 8'h40;
  localparam logic [7:0] RST_START_ADDRESS   = 8'hC0;
  localparam logic [7:0] RST_DISPLAY_CONTROL = 8'h89;

  // byte slots of one frame, in send order
  typedef enum logic [3:0] {
    SLOT_MODE     = 4'd0,
    SLOT_DATA_CMD = 4'd1,
    SLOT_ADDR     = 4'd2,
    SLOT_D1_HI    = 4'd3,
    SLOT_D1_LO    = 4'd4,
    SLOT_D2_HI    = 4'd5,
    SLOT_D2_LO    = 4'd6,
    SLOT_D3_HI    = 4'd7,
    SLOT_D3_LO    = 4'd8,
    SLOT_D4_HI    = 4'd9,
    SLOT_D4_LO    = 4'd10,
    SLOT_LED      = 4'd11,
    SLOT_PAD      = 4'd12,
    SLOT_CTRL     = 4'd13
  } slot_t;

  typedef struct packed {
    logic [3:0] digit_one;
    logic [3:0] digit_two;
    logic [3:0] digit_three;
    logic [3:0] digit_four;
    logic [2:0] dot_position;
    logic       colon_on;
    logic [7:0] led_bits;
  } in_word_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic [7:0] display_mode;
    logic [7:0] data_command;
    logic [7:0] start_address;
    logic [7:0] display_control;
  } cfg_regs_t;

  // seven-segment patterns, blank for 10 and up
  function automatic logic [7:0] seg_lookup(input logic [3:0] value);
    logic [7:0] seg;
    case (value)
      4'd0: seg = 8'h3F;
      4'd1: seg = 8'h06;
      4'd2: seg = 8'h5B;
      4'd3: seg = 8'h4F;
      4'd4: seg = 8'h66;
      4'd5: seg = 8'h6D;
      4'd6: seg = 8'h7D;
      4'd7: seg = 8'h07;
      4'd8: seg = 8'h7F;
      4'd9: seg = 8'h6F;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

endpackage

FILE: design/ssfb_digit_lane.sv
// one digit lane: segment encode plus decimal point
module ssfb_digit_lane (
  input  logic [3:0] digit,
  input  logic [2:0] dot_position,
  input  logic [2:0] lane_pos,
  output logic [7:0] seg_byte
);

  // table lookup, dot bit when this lane is the chosen digit
  always_comb begin
    seg_byte = ssfb_pkg::seg_lookup(digit);
    if (dot_position == lane_pos) begin
      seg_byte = seg_byte | ssfb_pkg::DOT_BIT;
    end
  end

endmodule

FILE: design/ssfb_cfg_regs.sv
// command byte registers behind the apb port
module ssfb_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ssfb_pkg::CFG_AW-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output ssfb_pkg::cfg_regs_t          cfg
);

  ssfb_pkg::cfg_regs_t cfg_r;
  ssfb_pkg::reg_idx_t  reg_sel;
  logic                wr_en;

  assign pready  = 1'b1;
  assign reg_sel = ssfb_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite;
  assign cfg     = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.display_mode    <= ssfb_pkg::RST_DISPLAY_MODE;
      cfg_r.data_command    <= ssfb_pkg::RST_DATA_COMMAND;
      cfg_r.start_address   <= ssfb_pkg::RST_START_ADDRESS;
      cfg_r.display_control <= ssfb_pkg::RST_DISPLAY_CONTROL;
    end else if (wr_en) begin
      case (reg_sel)
        ssfb_pkg::REG_DISPLAY_MODE:    cfg_r.display_mode    <= pwdata[7:0];
        ssfb_pkg::REG_DATA_COMMAND:    cfg_r.data_command    <= pwdata[7:0];
        ssfb_pkg::REG_START_ADDRESS:   cfg_r.start_address   <= pwdata[7:0];
        ssfb_pkg::REG_DISPLAY_CONTROL: cfg_r.display_control <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_sel)
      ssfb_pkg::REG_DISPLAY_MODE:    prdata = {24'd0, cfg_r.display_mode};
      ssfb_pkg::REG_DATA_COMMAND:    prdata = {24'd0, cfg_r.data_command};
      ssfb_pkg::REG_START_ADDRESS:   prdata = {24'd0, cfg_r.start_address};
      ssfb_pkg::REG_DISPLAY_CONTROL: prdata = {24'd0, cfg_r.display_control};
      default:                       prdata = 32'd0;
    endcase
  end

endmodule

FILE: design/ssfb_frame_seq.sv
// merges lane results into a frame and sends it one byte per cycle
module ssfb_frame_seq (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                load,
  input  logic [ssfb_pkg::NUM_DIGITS-1:0][7:0] seg_bytes,
  input  logic                                colon_on,
  input  logic [7:0]                          led_bits,
  input  ssfb_pkg::cfg_regs_t                 cfg,
  output logic                                busy,
  output logic                                out_valid,
  output ssfb_pkg::out_word_t                 out_word
);

  logic [ssfb_pkg::NUM_DIGITS-1:0][7:0] seg_r;
  logic [7:0]          colon_r;
  logic [7:0]          led_r;
  logic                active_r;
  logic                active_nxt;
  ssfb_pkg::slot_t     idx_r;
  ssfb_pkg::slot_t     idx_nxt;
  logic                out_valid_r;
  ssfb_pkg::out_word_t out_word_r;
  ssfb_pkg::out_word_t out_word_nxt;
  logic                at_end;

  assign at_end    = (idx_r == ssfb_pkg::SLOT_CTRL);
  assign busy      = active_r && !at_end;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // frame payload, loaded from the lanes on accept
  always_ff @(posedge clk) begin
    if (load) begin
      seg_r   <= seg_bytes;
      colon_r <= colon_on ? ssfb_pkg::COLON_BYTE : ssfb_pkg::ZERO_BYTE;
      led_r   <= led_bits;
    end
  end

  // slot counter
  always_comb begin
    active_nxt = active_r;
    idx_nxt    = idx_r;
    if (load) begin
      active_nxt = 1'b1;
      idx_nxt    = ssfb_pkg::SLOT_MODE;
    end else if (active_r) begin
      if (at_end) begin
        active_nxt = 1'b0;
      end else begin
        idx_nxt = ssfb_pkg::slot_t'(idx_r + 4'd1);
      end
    end
  end

  // byte select for the current slot
  always_comb begin
    out_word_nxt = '0;
    case (idx_r)
      ssfb_pkg::SLOT_MODE: begin
        out_word_nxt.frame_byte = cfg.display_mode;
        out_word_nxt.frame_end  = 1'b1;
      end
      ssfb_pkg::SLOT_DATA_CMD: begin
        out_word_nxt.frame_byte = cfg.data_command;
        out_word_nxt.frame_end  = 1'b1;
      end
      ssfb_pkg::SLOT_ADDR:  out_word_nxt.frame_byte = cfg.start_address;
      ssfb_pkg::SLOT_D1_HI: out_word_nxt.frame_byte = seg_r[0];
      ssfb_pkg::SLOT_D1_LO: out_word_nxt.frame_byte = ssfb_pkg::ZERO_BYTE;
      ssfb_pkg::SLOT_D2_HI: out_word_nxt.frame_byte = seg_r[1];
      ssfb_pkg::SLOT_D2_LO: out_word_nxt.frame_byte = colon_r;
      ssfb_pkg::SLOT_D3_HI: out_word_nxt.frame_byte = seg_r[2];
      ssfb_pkg::SLOT_D3_LO: out_word_nxt.frame_byte = colon_r;
      ssfb_pkg::SLOT_D4_HI: out_word_nxt.frame_byte = seg_r[3];
      ssfb_pkg::SLOT_D4_LO: out_word_nxt.frame_byte = ssfb_pkg::ZERO_BYTE;
      ssfb_pkg::SLOT_LED:   out_word_nxt.frame_byte = led_r;
      ssfb_pkg::SLOT_PAD: begin
        out_word_nxt.frame_byte = ssfb_pkg::ZERO_BYTE;
        out_word_nxt.frame_end  = 1'b1;
      end
      ssfb_pkg::SLOT_CTRL: begin
        out_word_nxt.frame_byte = cfg.display_control;
        out_word_nxt.frame_end  = 1'b1;
        out_word_nxt.last       = 1'b1;
      end
      default: out_word_nxt = '0;
    endcase
  end

  // control and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      idx_r       <= ssfb_pkg::SLOT_MODE;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= active_r;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

`ifndef SYNTHESIS
  // a load into an idle sequencer puts the slot counter on the mode slot next cycle
  a_load_opens: assert property (@(posedge clk) disable iff (!rst_n)
    load && !active_r |=> active_r && idx_r == ssfb_pkg::SLOT_MODE)
    else $error("load did not restart the slot counter");

  // sequencer finishes after the control byte when nothing new arrives
  a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    active_r && at_end && !load |=> !active_r)
    else $error("sequencer kept running past the last slot");

  // a valid last flag always comes with frame_end and follows the control slot
  a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.last |-> out_word_r.frame_end && $past(at_end))
    else $error("last byte out of place");

  // the output strobe is high only where the active flag was set the cycle before
  a_valid_track: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(active_r))
    else $error("output strobe without an active frame");
`endif

endmodule

FILE: design/seven_segment_frame_builder_core.sv
// top level of the seven-segment driver command frame builder
// An update is taken when start is high and busy is low; it yields fourteen
// command bytes on out_word, one per cycle with out_valid high, each selected
// by the slot counter and held in the output register. The sequencer sends
// one byte per clock; busy drops in the cycle before the final byte goes
// out, so the next update can be accepted in that cycle and its first byte
// follows the final byte with no gap. The receiver cannot stall: each byte is
// valid for exactly one cycle. Four digit lanes encode the digits in parallel
// at accept time. Command bytes come from registers at 0x0, 0x4, 0x8 and 0xC.
module seven_segment_frame_builder_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  ssfb_pkg::in_word_t          in_word,
  output logic                        out_valid,
  output ssfb_pkg::out_word_t         out_word,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ssfb_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  ssfb_pkg::cfg_regs_t                  cfg;
  logic [ssfb_pkg::NUM_DIGITS-1:0][3:0] digits;
  logic [ssfb_pkg::NUM_DIGITS-1:0][7:0] seg_bytes;
  logic                                 accept;

  assign accept = start && !busy;
  assign digits = {in_word.digit_four, in_word.digit_three,
                   in_word.digit_two, in_word.digit_one};

  // configuration registers
  ssfb_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // digit lanes, positions one to four
  for (genvar g = 0; g < ssfb_pkg::NUM_DIGITS; g++) begin : g_lane
    ssfb_digit_lane u_lane (
      .digit        (digits[g]),
      .dot_position (in_word.dot_position),
      .lane_pos     (3'(g + 1)),
      .seg_byte     (seg_bytes[g])
    );
  end

  // frame merge and byte sequencer
  ssfb_frame_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .seg_bytes (seg_bytes),
    .colon_on  (in_word.colon_on),
    .led_bits  (in_word.led_bits),
    .cfg       (cfg),
    .busy      (busy),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule
